/* rtl/mlt_pkg.sv */
// Shared constants, codes, control types and mode functions for the lock table
package mlt_pkg;

	localparam int DEF_NUM_HEADS = 16;
	localparam int DEF_NUM_SLOTS = 32;
	localparam int DEF_KEY_BITS  = 32;
	localparam int DEF_TXN_BITS  = 8;
	localparam int MODE_BITS     = 3;
	localparam int MODE_MAX      = 6;

	// Input commands
	localparam logic [1:0] CMD_LOCK   = 2'd0;
	localparam logic [1:0] CMD_UNLOCK = 2'd1;
	localparam logic [1:0] CMD_ALL    = 2'd2;

	// Result kinds
	localparam logic [2:0] KIND_GRANT    = 3'd0;
	localparam logic [2:0] KIND_QUEUED   = 3'd1;
	localparam logic [2:0] KIND_WAKE     = 3'd2;
	localparam logic [2:0] KIND_DONE     = 3'd3;
	localparam logic [2:0] KIND_NOTFOUND = 3'd4;
	localparam logic [2:0] KIND_FULL     = 3'd5;

	// Datapath operations
	localparam logic [4:0] OP_NONE     = 5'd0;
	localparam logic [4:0] OP_LOAD     = 5'd1;
	localparam logic [4:0] OP_HNEXT    = 5'd2;
	localparam logic [4:0] OP_LFRESH   = 5'd3;
	localparam logic [4:0] OP_LSETUP   = 5'd4;
	localparam logic [4:0] OP_CNEXT    = 5'd5;
	localparam logic [4:0] OP_LAPPEND  = 5'd6;
	localparam logic [4:0] OP_UFIRST   = 5'd7;
	localparam logic [4:0] OP_SETS     = 5'd8;
	localparam logic [4:0] OP_RMSTART  = 5'd9;
	localparam logic [4:0] OP_SETFIRST = 5'd10;
	localparam logic [4:0] OP_PSTART   = 5'd11;
	localparam logic [4:0] OP_LINK     = 5'd12;
	localparam logic [4:0] OP_HFREE    = 5'd13;
	localparam logic [4:0] OP_RBSTART  = 5'd14;
	localparam logic [4:0] OP_RBA      = 5'd15;
	localparam logic [4:0] OP_RBGRANT  = 5'd16;
	localparam logic [4:0] OP_RBDONE   = 5'd17;
	localparam logic [4:0] OP_SNEXT    = 5'd18;

	// Compatibility rows: row is requested mode, bit is group mode
	localparam logic [6:0] COMPAT_TAB [0:6] = '{
		7'b0000000,
		7'b0011111,
		7'b0000111,
		7'b0001011,
		7'b0000011,
		7'b0001001,
		7'b0000001
	};

	typedef struct packed {
		logic [4:0] op;
		logic       emit;
		logic [2:0] kind;
		logic       last;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       found;
		logic       head_hit;
		logic       h_last;
		logic       s_last;
		logic       fs_ok;
		logic       fh_ok;
		logic       c_end;
		logic       c_used;
		logic       c_txn_hit;
		logic       c_next_end;
		logic       c_next_is_s;
		logic       c_granted;
		logic       c_compat;
		logic       first_is_s;
		logic       first_end;
		logic       lock_grant;
		logic       out_free;
	} sts_t;

	function automatic logic compatible(input logic [2:0] req, input logic [2:0] grp);
		logic [6:0] row;
		row = '0;
		if (req <= 3'(MODE_MAX) && grp <= 3'(MODE_MAX)) begin
			row = COMPAT_TAB[req];
		end
		return (grp <= 3'(MODE_MAX)) ? row[grp] : 1'b0;
	endfunction

	function automatic logic [2:0] max_mode(input logic [2:0] a, input logic [2:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

/* rtl/mlt_if.sv */
// Command and result channel interfaces of the lock table
interface mlt_cmd_if #(
	parameter int KEY_BITS = mlt_pkg::DEF_KEY_BITS,
	parameter int TXN_BITS = mlt_pkg::DEF_TXN_BITS
);
	logic                valid;
	logic                ready;
	logic [1:0]          command;
	logic [TXN_BITS-1:0] txn_id;
	logic [KEY_BITS-1:0] lock_key;
	logic [2:0]          lock_mode;

	modport source (output valid, command, txn_id, lock_key, lock_mode, input ready);
	modport sink (input valid, command, txn_id, lock_key, lock_mode, output ready);
endinterface

interface mlt_res_if #(
	parameter int KEY_BITS = mlt_pkg::DEF_KEY_BITS,
	parameter int TXN_BITS = mlt_pkg::DEF_TXN_BITS
);
	logic                valid;
	logic                ready;
	logic [2:0]          kind;
	logic [TXN_BITS-1:0] out_txn;
	logic [KEY_BITS-1:0] out_key;
	logic [2:0]          out_mode;
	logic                last;

	modport source (output valid, kind, out_txn, out_key, out_mode, last, input ready);
	modport sink (input valid, kind, out_txn, out_key, out_mode, last, output ready);
endinterface

/* rtl/mlt_ctrl.sv */
// Controller state machine: sequences head search, list walks, removal and regrant
module mlt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    in_command,
	output logic          in_ready,
	input  mlt_pkg::sts_t sts,
	output mlt_pkg::ctl_t ctl
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_FIND   = 4'd1;
	localparam logic [3:0] ST_LTAIL  = 4'd2;
	localparam logic [3:0] ST_UWALK  = 4'd3;
	localparam logic [3:0] ST_RMSTRT = 4'd4;
	localparam logic [3:0] ST_RMLINK = 4'd5;
	localparam logic [3:0] ST_RMPRED = 4'd6;
	localparam logic [3:0] ST_RMCHK  = 4'd7;
	localparam logic [3:0] ST_RBA    = 4'd8;
	localparam logic [3:0] ST_RBB    = 4'd9;
	localparam logic [3:0] ST_ADV    = 4'd10;
	localparam logic [3:0] ST_SWEEP  = 4'd11;
	localparam logic [3:0] ST_FINAL  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	// Pick next state and datapath operation
	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		ctl.op    = mlt_pkg::OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.op = mlt_pkg::OP_LOAD;
					case (in_command) inside
						mlt_pkg::CMD_LOCK, mlt_pkg::CMD_UNLOCK: state_nxt = ST_FIND;
						mlt_pkg::CMD_ALL: state_nxt = ST_SWEEP;
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_FIND: begin
				if (sts.head_hit) begin
					if (sts.cmd == mlt_pkg::CMD_LOCK) begin
						if (sts.fs_ok) begin
							ctl.op    = mlt_pkg::OP_LSETUP;
							state_nxt = ST_LTAIL;
						end else if (sts.out_free) begin
							ctl.emit  = 1'b1;
							ctl.kind  = mlt_pkg::KIND_FULL;
							ctl.last  = 1'b1;
							state_nxt = ST_IDLE;
						end
					end else begin
						ctl.op    = mlt_pkg::OP_UFIRST;
						state_nxt = ST_UWALK;
					end
				end else if (sts.h_last) begin
					if (sts.out_free) begin
						ctl.emit  = 1'b1;
						ctl.last  = 1'b1;
						state_nxt = ST_IDLE;
						if (sts.cmd != mlt_pkg::CMD_LOCK) begin
							ctl.kind = mlt_pkg::KIND_NOTFOUND;
						end else if (sts.fs_ok && sts.fh_ok) begin
							ctl.op   = mlt_pkg::OP_LFRESH;
							ctl.kind = mlt_pkg::KIND_GRANT;
						end else begin
							ctl.kind = mlt_pkg::KIND_FULL;
						end
					end
				end else begin
					ctl.op = mlt_pkg::OP_HNEXT;
				end
			end
			ST_LTAIL: begin
				if (sts.c_next_end) begin
					if (sts.out_free) begin
						ctl.op    = mlt_pkg::OP_LAPPEND;
						ctl.emit  = 1'b1;
						ctl.kind  = sts.lock_grant ? mlt_pkg::KIND_GRANT : mlt_pkg::KIND_QUEUED;
						ctl.last  = 1'b1;
						state_nxt = ST_IDLE;
					end
				end else begin
					ctl.op = mlt_pkg::OP_CNEXT;
				end
			end
			ST_UWALK: begin
				if (sts.c_end) begin
					if (sts.out_free) begin
						ctl.emit  = 1'b1;
						ctl.kind  = mlt_pkg::KIND_NOTFOUND;
						ctl.last  = 1'b1;
						state_nxt = ST_IDLE;
					end
				end else if (sts.c_txn_hit) begin
					ctl.op    = mlt_pkg::OP_SETS;
					state_nxt = ST_RMSTRT;
				end else begin
					ctl.op = mlt_pkg::OP_CNEXT;
				end
			end
			ST_RMSTRT: begin
				ctl.op    = mlt_pkg::OP_RMSTART;
				state_nxt = ST_RMLINK;
			end
			ST_SWEEP: begin
				if (sts.c_used && sts.c_txn_hit) begin
					ctl.op    = mlt_pkg::OP_RMSTART;
					state_nxt = ST_RMLINK;
				end else if (sts.s_last) begin
					state_nxt = ST_FINAL;
				end else begin
					ctl.op = mlt_pkg::OP_SNEXT;
				end
			end
			ST_RMLINK: begin
				if (sts.first_is_s) begin
					ctl.op    = mlt_pkg::OP_SETFIRST;
					state_nxt = ST_RMCHK;
				end else begin
					ctl.op    = mlt_pkg::OP_PSTART;
					state_nxt = ST_RMPRED;
				end
			end
			ST_RMPRED: begin
				if (sts.c_next_is_s) begin
					ctl.op    = mlt_pkg::OP_LINK;
					state_nxt = ST_RMCHK;
				end else begin
					ctl.op = mlt_pkg::OP_CNEXT;
				end
			end
			ST_RMCHK: begin
				if (sts.first_end) begin
					ctl.op    = mlt_pkg::OP_HFREE;
					state_nxt = ST_ADV;
				end else begin
					ctl.op    = mlt_pkg::OP_RBSTART;
					state_nxt = ST_RBA;
				end
			end
			ST_RBA: begin
				if (sts.c_end) begin
					ctl.op    = mlt_pkg::OP_RBDONE;
					state_nxt = ST_ADV;
				end else if (sts.c_granted) begin
					ctl.op = mlt_pkg::OP_RBA;
				end else begin
					state_nxt = ST_RBB;
				end
			end
			ST_RBB: begin
				if (sts.c_end || !sts.c_compat) begin
					ctl.op    = mlt_pkg::OP_RBDONE;
					state_nxt = ST_ADV;
				end else if (sts.out_free) begin
					ctl.op   = mlt_pkg::OP_RBGRANT;
					ctl.emit = 1'b1;
					ctl.kind = mlt_pkg::KIND_WAKE;
				end
			end
			ST_ADV: begin
				if (sts.cmd == mlt_pkg::CMD_UNLOCK || sts.s_last) begin
					state_nxt = ST_FINAL;
				end else begin
					ctl.op    = mlt_pkg::OP_SNEXT;
					state_nxt = ST_SWEEP;
				end
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					ctl.emit  = 1'b1;
					ctl.kind  = sts.found ? mlt_pkg::KIND_DONE : mlt_pkg::KIND_NOTFOUND;
					ctl.last  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* rtl/mlt_dp.sv */
// Datapath: head and slot tables, cursors, group mode and result register
module mlt_dp #(
	parameter int NUM_HEADS = mlt_pkg::DEF_NUM_HEADS,
	parameter int NUM_SLOTS = mlt_pkg::DEF_NUM_SLOTS,
	parameter int KEY_BITS  = mlt_pkg::DEF_KEY_BITS,
	parameter int TXN_BITS  = mlt_pkg::DEF_TXN_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          in_command,
	input  logic [TXN_BITS-1:0] in_txn,
	input  logic [KEY_BITS-1:0] in_key,
	input  logic [2:0]          in_mode,
	input  mlt_pkg::ctl_t       ctl,
	output mlt_pkg::sts_t       sts,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [2:0]          res_kind,
	output logic [TXN_BITS-1:0] res_txn,
	output logic [KEY_BITS-1:0] res_key,
	output logic [2:0]          res_mode,
	output logic                res_last
);

	localparam int HIW = $clog2(NUM_HEADS);
	localparam int SIW = $clog2(NUM_SLOTS);
	localparam int SPW = $clog2(NUM_SLOTS + 1);
	localparam logic [SPW-1:0] END_PTR = SPW'(NUM_SLOTS);

	// Tables
	logic                head_used_q  [NUM_HEADS];
	logic [KEY_BITS-1:0] head_key_q   [NUM_HEADS];
	logic [2:0]          head_gm_q    [NUM_HEADS];
	logic                head_wait_q  [NUM_HEADS];
	logic [SPW-1:0]      head_first_q [NUM_HEADS];
	logic                slot_used_q  [NUM_SLOTS];
	logic [SPW-1:0]      slot_next_q  [NUM_SLOTS];
	logic [HIW-1:0]      slot_head_q  [NUM_SLOTS];
	logic [2:0]          slot_mode_q  [NUM_SLOTS];
	logic                slot_gr_q    [NUM_SLOTS];
	logic [TXN_BITS-1:0] slot_txn_q   [NUM_SLOTS];

	// Item and walk registers
	logic [1:0]          cmd_q;
	logic [TXN_BITS-1:0] txn_q;
	logic [KEY_BITS-1:0] key_q;
	logic [2:0]          mode_q;
	logic [HIW-1:0]      h_q;
	logic [SPW-1:0]      c_q;
	logic [SPW-1:0]      s_q;
	logic [SPW-1:0]      snext_q;
	logic [2:0]          m_q;
	logic [2:0]          g_q;
	logic                found_q;
	logic                ov_q;

	logic [SIW-1:0] ci;
	logic [SIW-1:0] si;
	logic [SIW-1:0] fs;
	logic [HIW-1:0] fh;
	logic           fs_ok;
	logic           fh_ok;
	logic           out_free;
	logic           grant;

	assign ci       = c_q[SIW-1:0];
	assign si       = s_q[SIW-1:0];
	assign out_free = !ov_q || res_ready;
	assign grant    = !head_wait_q[h_q] && mlt_pkg::compatible(mode_q, head_gm_q[h_q]);

	// Find the lowest free slot and head
	always_comb begin
		fs    = '0;
		fs_ok = 1'b0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				fs    = SIW'(i);
				fs_ok = 1'b1;
			end
		end
	end

	always_comb begin
		fh    = '0;
		fh_ok = 1'b0;
		for (int i = NUM_HEADS - 1; i >= 0; i--) begin
			if (!head_used_q[i]) begin
				fh    = HIW'(i);
				fh_ok = 1'b1;
			end
		end
	end

	// Status to the controller
	always_comb begin
		sts             = '0;
		sts.cmd         = cmd_q;
		sts.found       = found_q;
		sts.head_hit    = head_used_q[h_q] && (head_key_q[h_q] == key_q);
		sts.h_last      = (h_q == HIW'(NUM_HEADS - 1));
		sts.s_last      = (s_q == SPW'(NUM_SLOTS - 1));
		sts.fs_ok       = fs_ok;
		sts.fh_ok       = fh_ok;
		sts.c_end       = (c_q == END_PTR);
		sts.c_used      = slot_used_q[ci];
		sts.c_txn_hit   = (slot_txn_q[ci] == txn_q);
		sts.c_next_end  = (slot_next_q[ci] == END_PTR);
		sts.c_next_is_s = (slot_next_q[ci] == s_q);
		sts.c_granted   = slot_gr_q[ci];
		sts.c_compat    = mlt_pkg::compatible(slot_mode_q[ci], g_q);
		sts.first_is_s  = (head_first_q[h_q] == s_q);
		sts.first_end   = (head_first_q[h_q] == END_PTR);
		sts.lock_grant  = grant;
		sts.out_free    = out_free;
	end

	// Control state of the tables and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_HEADS; i++) begin
				head_used_q[i] <= 1'b0;
				head_gm_q[i]   <= '0;
				head_wait_q[i] <= 1'b0;
			end
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_used_q[i] <= 1'b0;
			end
			cmd_q   <= '0;
			h_q     <= '0;
			c_q     <= '0;
			s_q     <= '0;
			g_q     <= '0;
			found_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			case (ctl.op)
				mlt_pkg::OP_LOAD: begin
					cmd_q   <= in_command;
					h_q     <= '0;
					c_q     <= '0;
					s_q     <= '0;
					found_q <= 1'b0;
				end
				mlt_pkg::OP_HNEXT: h_q <= h_q + 1'b1;
				mlt_pkg::OP_LFRESH: begin
					slot_used_q[fs] <= 1'b1;
					head_used_q[fh] <= 1'b1;
					head_gm_q[fh]   <= mode_q;
					head_wait_q[fh] <= 1'b0;
				end
				mlt_pkg::OP_LSETUP: begin
					s_q <= SPW'(fs);
					c_q <= head_first_q[h_q];
				end
				mlt_pkg::OP_CNEXT: c_q <= slot_next_q[ci];
				mlt_pkg::OP_LAPPEND: begin
					slot_used_q[si] <= 1'b1;
					if (grant) begin
						head_gm_q[h_q] <= mlt_pkg::max_mode(mode_q, head_gm_q[h_q]);
					end else begin
						head_wait_q[h_q] <= 1'b1;
					end
				end
				mlt_pkg::OP_UFIRST: c_q <= head_first_q[h_q];
				mlt_pkg::OP_SETS: s_q <= c_q;
				mlt_pkg::OP_RMSTART: begin
					slot_used_q[ci] <= 1'b0;
					h_q             <= slot_head_q[ci];
					found_q         <= 1'b1;
				end
				mlt_pkg::OP_PSTART: c_q <= head_first_q[h_q];
				mlt_pkg::OP_HFREE: begin
					head_used_q[h_q] <= 1'b0;
					head_gm_q[h_q]   <= '0;
					head_wait_q[h_q] <= 1'b0;
				end
				mlt_pkg::OP_RBSTART: begin
					c_q <= head_first_q[h_q];
					g_q <= '0;
				end
				mlt_pkg::OP_RBA, mlt_pkg::OP_RBGRANT: begin
					g_q <= mlt_pkg::max_mode(slot_mode_q[ci], g_q);
					c_q <= slot_next_q[ci];
				end
				mlt_pkg::OP_RBDONE: begin
					head_gm_q[h_q]   <= g_q;
					head_wait_q[h_q] <= (c_q != END_PTR);
				end
				mlt_pkg::OP_SNEXT: begin
					s_q <= s_q + 1'b1;
					c_q <= s_q + 1'b1;
				end
				default: ;
			endcase
			// Load or drop the result item
			if (ctl.emit) begin
				ov_q <= 1'b1;
			end else if (res_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Payload of the tables and item registers
	always_ff @(posedge clk) begin
		case (ctl.op)
			mlt_pkg::OP_LOAD: begin
				txn_q  <= in_txn;
				key_q  <= in_key;
				mode_q <= in_mode;
			end
			mlt_pkg::OP_LFRESH: begin
				slot_next_q[fs]  <= END_PTR;
				slot_head_q[fs]  <= fh;
				slot_mode_q[fs]  <= mode_q;
				slot_txn_q[fs]   <= txn_q;
				slot_gr_q[fs]    <= 1'b1;
				head_key_q[fh]   <= key_q;
				head_first_q[fh] <= SPW'(fs);
			end
			mlt_pkg::OP_LAPPEND: begin
				slot_next_q[ci] <= s_q;
				slot_next_q[si] <= END_PTR;
				slot_head_q[si] <= h_q;
				slot_mode_q[si] <= mode_q;
				slot_txn_q[si]  <= txn_q;
				slot_gr_q[si]   <= grant;
			end
			mlt_pkg::OP_RMSTART: begin
				snext_q <= slot_next_q[ci];
				m_q     <= slot_mode_q[ci];
			end
			mlt_pkg::OP_SETFIRST: head_first_q[h_q] <= snext_q;
			mlt_pkg::OP_LINK: slot_next_q[ci] <= snext_q;
			mlt_pkg::OP_RBGRANT: slot_gr_q[ci] <= 1'b1;
			default: ;
		endcase
		// Build the result payload by kind
		if (ctl.emit) begin
			res_kind <= ctl.kind;
			res_last <= ctl.last;
			res_txn  <= txn_q;
			res_key  <= key_q;
			res_mode <= mode_q;
			case (ctl.kind)
				mlt_pkg::KIND_WAKE: begin
					res_txn  <= slot_txn_q[ci];
					res_key  <= head_key_q[h_q];
					res_mode <= slot_mode_q[ci];
				end
				mlt_pkg::KIND_DONE: begin
					res_mode <= (cmd_q == mlt_pkg::CMD_UNLOCK) ? m_q : 3'd0;
					if (cmd_q == mlt_pkg::CMD_ALL) begin
						res_key <= '0;
					end
				end
				mlt_pkg::KIND_NOTFOUND: begin
					res_mode <= 3'd0;
					if (cmd_q == mlt_pkg::CMD_ALL) begin
						res_key <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign res_valid = ov_q;

endmodule

/* rtl/multimode_lock_table.sv */
// Top level of the multimode lock table: controller, datapath and channel wiring
//
//  channel  modport  role     payload
//  cmd_ch   sink     command  command, txn_id, lock_key, lock_mode
//  res_ch   source   result   kind, out_txn, out_key, out_mode, last
//
// One command at a time. A key lookup scans heads one per cycle (up to NUM_HEADS),
// then list walks take one slot per cycle; a removal costs a predecessor walk plus
// a regrant walk, so unlock-all sweeps NUM_SLOTS slots plus those walks per hit.
// Results are registered until res_ch takes them; a stalled result holds the walk.
// Reset clears every used bit at once: no clearing pass.
module multimode_lock_table #(
	parameter int NUM_HEADS = mlt_pkg::DEF_NUM_HEADS,
	parameter int NUM_SLOTS = mlt_pkg::DEF_NUM_SLOTS,
	parameter int KEY_BITS  = mlt_pkg::DEF_KEY_BITS,
	parameter int TXN_BITS  = mlt_pkg::DEF_TXN_BITS
) (
	input logic      clk,
	input logic      arst_n,
	mlt_cmd_if.sink  cmd_ch,
	mlt_res_if.source res_ch
);

	mlt_pkg::ctl_t ctl;
	mlt_pkg::sts_t sts;
	logic          in_ready;

	assign cmd_ch.ready = in_ready;

	mlt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd_ch.valid),
		.in_command (cmd_ch.command),
		.in_ready   (in_ready),
		.sts        (sts),
		.ctl        (ctl)
	);

	mlt_dp #(
		.NUM_HEADS (NUM_HEADS),
		.NUM_SLOTS (NUM_SLOTS),
		.KEY_BITS  (KEY_BITS),
		.TXN_BITS  (TXN_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_command (cmd_ch.command),
		.in_txn     (cmd_ch.txn_id),
		.in_key     (cmd_ch.lock_key),
		.in_mode    (cmd_ch.lock_mode),
		.ctl        (ctl),
		.sts        (sts),
		.res_valid  (res_ch.valid),
		.res_ready  (res_ch.ready),
		.res_kind   (res_ch.kind),
		.res_txn    (res_ch.out_txn),
		.res_key    (res_ch.out_key),
		.res_mode   (res_ch.out_mode),
		.res_last   (res_ch.last)
	);

endmodule

/* tb/multimode_lock_table_test.sv */
// Testbench for the multimode lock table: queued stimulus, lock-table predictor, result checker
`timescale 1ns / 100ps

module multimode_lock_table_test;

	localparam int NH = mlt_pkg::DEF_NUM_HEADS;
	localparam int NS = mlt_pkg::DEF_NUM_SLOTS;
	localparam int LIMIT = 2000000;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  txn;
		logic [31:0] key;
		logic [2:0]  mode;
	} lock_cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  txn;
		logic [31:0] key;
		logic [2:0]  mode;
		logic        last;
	} lock_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mlt_cmd_if cmd_ch ();
	mlt_res_if res_ch ();

	multimode_lock_table u_top (.clk(clk), .arst_n(arst_n), .cmd_ch(cmd_ch), .res_ch(res_ch));

	always #6 clk = ~clk;

	// Predictor copy of the lock table
	bit          p_hused [NH];
	logic [31:0] p_hkey [NH];
	logic [2:0]  p_hgrp [NH];
	bit          p_hwait [NH];
	int          p_hfirst [NH];
	bit          p_sused [NS];
	int          p_snext [NS];
	int          p_shead [NS];
	logic [2:0]  p_smode [NS];
	bit          p_sgrant [NS];
	logic [7:0]  p_stxn [NS];

	lock_cmd_t pending_cmds [$];
	lock_res_t expected_res [$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	bit stim_done = 1'b0;

	function automatic bit compat_ok(logic [2:0] r, logic [2:0] g);
		bit [6:0] rows [7];
		rows = '{7'b0000000, 7'b0011111, 7'b0000111, 7'b0001011,
			7'b0000011, 7'b0001001, 7'b0000001};
		if (r > 3'd6 || g > 3'd6) return 1'b0;
		return rows[r][g];
	endfunction

	function automatic logic [2:0] mode_max(logic [2:0] a, logic [2:0] b);
		return (a > b) ? a : b;
	endfunction

	task automatic push_res(logic [2:0] k, logic [7:0] t, logic [31:0] ky, logic [2:0] m);
		lock_res_t r;
		r = '{kind: k, txn: t, key: ky, mode: m, last: 1'b0};
		expected_res.push_back(r);
	endtask

	function automatic int head_of(logic [31:0] key);
		for (int h = 0; h < NH; h++)
			if (p_hused[h] && p_hkey[h] == key) return h;
		return NH;
	endfunction

	// Recompute group mode and wake compatible waiters
	task automatic regrant(int h);
		logic [2:0] g;
		int c;
		g = '0;
		c = p_hfirst[h];
		while (c < NS && p_sgrant[c]) begin
			g = mode_max(p_smode[c], g);
			c = p_snext[c];
		end
		while (c < NS && compat_ok(p_smode[c], g)) begin
			g = mode_max(p_smode[c], g);
			p_sgrant[c] = 1'b1;
			push_res(mlt_pkg::KIND_WAKE, p_stxn[c], p_hkey[h], p_smode[c]);
			c = p_snext[c];
		end
		p_hgrp[h] = g;
		p_hwait[h] = (c < NS);
	endtask

	task automatic drop_slot(int s);
		int h, p;
		h = p_shead[s];
		if (p_hfirst[h] == s) p_hfirst[h] = p_snext[s];
		else begin
			p = p_hfirst[h];
			while (p < NS && p_snext[p] != s) p = p_snext[p];
			if (p < NS) p_snext[p] = p_snext[s];
		end
		p_sused[s] = 1'b0;
		if (p_hfirst[h] >= NS) begin
			p_hused[h] = 1'b0;
			p_hgrp[h] = '0;
			p_hwait[h] = 1'b0;
		end else regrant(h);
	endtask

	task automatic predict(lock_cmd_t c);
		int h, s, t, n0;
		bit fresh, found;
		logic [2:0] m;
		n0 = expected_res.size();
		case (c.command)
			mlt_pkg::CMD_LOCK: begin
				h = head_of(c.key);
				fresh = 1'b0;
				s = 0;
				while (s < NS && p_sused[s]) s++;
				if (h == NH) begin
					h = 0;
					while (h < NH && p_hused[h]) h++;
					fresh = 1'b1;
				end
				if (s >= NS || h >= NH) push_res(mlt_pkg::KIND_FULL, c.txn, c.key, c.mode);
				else begin
					p_sused[s] = 1'b1;
					p_snext[s] = NS;
					p_shead[s] = h;
					p_smode[s] = c.mode;
					p_stxn[s] = c.txn;
					if (fresh) begin
						p_hused[h] = 1'b1;
						p_hkey[h] = c.key;
						p_hfirst[h] = s;
						p_hgrp[h] = c.mode;
						p_hwait[h] = 1'b0;
						p_sgrant[s] = 1'b1;
						push_res(mlt_pkg::KIND_GRANT, c.txn, c.key, c.mode);
					end else begin
						t = p_hfirst[h];
						while (t < NS && p_snext[t] < NS) t = p_snext[t];
						if (t < NS) p_snext[t] = s;
						else p_hfirst[h] = s;
						if (!p_hwait[h] && compat_ok(c.mode, p_hgrp[h])) begin
							p_hgrp[h] = mode_max(c.mode, p_hgrp[h]);
							p_sgrant[s] = 1'b1;
							push_res(mlt_pkg::KIND_GRANT, c.txn, c.key, c.mode);
						end else begin
							p_hwait[h] = 1'b1;
							p_sgrant[s] = 1'b0;
							push_res(mlt_pkg::KIND_QUEUED, c.txn, c.key, c.mode);
						end
					end
				end
			end
			mlt_pkg::CMD_UNLOCK: begin
				h = head_of(c.key);
				t = NS;
				if (h < NH) begin
					t = p_hfirst[h];
					while (t < NS && p_stxn[t] != c.txn) t = p_snext[t];
				end
				if (t >= NS) push_res(mlt_pkg::KIND_NOTFOUND, c.txn, c.key, 3'd0);
				else begin
					m = p_smode[t];
					drop_slot(t);
					push_res(mlt_pkg::KIND_DONE, c.txn, c.key, m);
				end
			end
			mlt_pkg::CMD_ALL: begin
				found = 1'b0;
				for (s = 0; s < NS; s++)
					if (p_sused[s] && p_stxn[s] == c.txn) begin
						found = 1'b1;
						drop_slot(s);
					end
				push_res(found ? mlt_pkg::KIND_DONE : mlt_pkg::KIND_NOTFOUND,
					c.txn, 32'd0, 3'd0);
			end
			default: ;
		endcase
		if (expected_res.size() > n0) expected_res[$].last = 1'b1;
	endtask

	task automatic report(string what, lock_res_t got, lock_res_t exp);
		errors++;
		if (errors <= 40)
			$display("mismatch %s: got k%0d t%0h key%0h m%0d l%0d exp k%0d t%0h key%0h m%0d l%0d",
				what, got.kind, got.txn, got.key, got.mode, got.last,
				exp.kind, exp.txn, exp.key, exp.mode, exp.last);
	endtask

	// Drive commands from the pending queue with random gaps
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predict('{cmd_ch.command, cmd_ch.txn_id, cmd_ch.lock_key, cmd_ch.lock_mode});
				if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
			end
			if (!(cmd_ch.valid && !cmd_ch.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					lock_cmd_t c;
					c = pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.command <= c.command;
					cmd_ch.txn_id <= c.txn;
					cmd_ch.lock_key <= c.key;
					cmd_ch.lock_mode <= c.mode;
				end else cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Check results and stall the receiver in bursts
	int stall_left = 0;
	always @(posedge clk) begin
		lock_res_t got, exp;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.kind, res_ch.out_txn, res_ch.out_key, res_ch.out_mode, res_ch.last};
				if (expected_res.size() == 0) report("unexpected", got, got);
				else begin
					exp = expected_res.pop_front();
					if (got.kind != exp.kind) report("kind", got, exp);
					else if (got.txn != exp.txn) report("out_txn", got, exp);
					else if (got.key != exp.key) report("out_key", got, exp);
					else if (got.mode != exp.mode) report("out_mode", got, exp);
					else if (got.last != exp.last) report("last", got, exp);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				res_ch.ready <= 1'b0;
			end else res_ch.ready <= 1'b1;
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic add_cmd(logic [1:0] cm, logic [7:0] t, logic [31:0] k, logic [2:0] m);
		pending_cmds.push_back('{cm, t, k, m});
	endtask

	initial begin
		logic [31:0] keys [8];
		int mode_hi;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = mlt_pkg::CMD_LOCK;
		cmd_ch.txn_id = '0;
		cmd_ch.lock_key = '0;
		cmd_ch.lock_mode = '0;
		res_ch.ready = 1'b0;
		for (int h = 0; h < NH; h++) begin
			p_hused[h] = 0; p_hgrp[h] = 0; p_hwait[h] = 0; p_hfirst[h] = 0; p_hkey[h] = 0;
		end
		for (int s = 0; s < NS; s++) begin
			p_sused[s] = 0; p_snext[s] = 0; p_shead[s] = 0;
			p_smode[s] = 0; p_sgrant[s] = 0; p_stxn[s] = 0;
		end

		// Directed: extremes, modes zero and seven, waiters, duplicates, not found, unknown
		add_cmd(mlt_pkg::CMD_LOCK, 8'h00, 32'h0000_0000, 3'd0);
		add_cmd(mlt_pkg::CMD_LOCK, 8'hFF, 32'h0000_0000, 3'd1);
		add_cmd(mlt_pkg::CMD_LOCK, 8'hFF, 32'hFFFF_FFFF, 3'd7);
		add_cmd(mlt_pkg::CMD_LOCK, 8'h01, 32'hFFFF_FFFF, 3'd1);
		add_cmd(mlt_pkg::CMD_LOCK, 8'h02, 32'h1234_5678, 3'd1);
		add_cmd(mlt_pkg::CMD_LOCK, 8'h03, 32'h1234_5678, 3'd2);
		add_cmd(mlt_pkg::CMD_LOCK, 8'h04, 32'h1234_5678, 3'd6);
		add_cmd(mlt_pkg::CMD_LOCK, 8'h05, 32'h1234_5678, 3'd1);
		add_cmd(mlt_pkg::CMD_LOCK, 8'h05, 32'h1234_5678, 3'd1);
		add_cmd(mlt_pkg::CMD_UNLOCK, 8'h04, 32'h1234_5678, 3'd0);
		add_cmd(mlt_pkg::CMD_UNLOCK, 8'h02, 32'h1234_5678, 3'd5);
		add_cmd(mlt_pkg::CMD_UNLOCK, 8'h09, 32'h1234_5678, 3'd0);
		add_cmd(mlt_pkg::CMD_UNLOCK, 8'h09, 32'hDEAD_BEEF, 3'd0);
		add_cmd(CMD_UNKNOWN, 8'hAA, 32'h5555_5555, 3'd3);
		add_cmd(mlt_pkg::CMD_ALL, 8'hFF, 32'hAAAA_AAAA, 3'd6);
		add_cmd(mlt_pkg::CMD_ALL, 8'h77, 32'h0, 3'd0);
		for (int i = 0; i < 17; i++)
			add_cmd(mlt_pkg::CMD_LOCK, 8'h10, 32'hC000_0000 + i, 3'd5);
		add_cmd(mlt_pkg::CMD_ALL, 8'h10, 32'h0, 3'd0);
		for (int i = 0; i < 34; i++)
			add_cmd(mlt_pkg::CMD_LOCK, 8'h20 + i[7:0], 32'h0000_0042, 3'd1);
		for (int t = 0; t < 6; t++) add_cmd(mlt_pkg::CMD_ALL, 8'h00 + t[7:0], 32'h0, 3'd0);
		for (int i = 0; i < 34; i++) add_cmd(mlt_pkg::CMD_ALL, 8'h20 + i[7:0], 32'h0, 3'd0);

		// Random: small key and txn pools to build queues, with full-range noise
		for (int i = 0; i < 280; i++) begin
			logic [1:0] cm;
			logic [7:0] t;
			logic [31:0] k;
			if (i % 100 == 0)
				for (int j = 0; j < 8; j++) keys[j] = $urandom;
			mode_hi = ($urandom_range(0, 9) == 0) ? 7 : 6;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: cm = mlt_pkg::CMD_LOCK;
				5, 6, 7: cm = mlt_pkg::CMD_UNLOCK;
				8: cm = mlt_pkg::CMD_ALL;
				default: cm = ($urandom_range(0, 3) == 0) ? CMD_UNKNOWN : mlt_pkg::CMD_UNLOCK;
			endcase
			t = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			k = ($urandom_range(0, 7) == 0) ? $urandom : keys[$urandom_range(0, 7)];
			add_cmd(cm, t, k, 3'($urandom_range(0, mode_hi)));
		end
		// Drain the pooled transactions at the end
		for (int t = 0; t < 8; t++) add_cmd(mlt_pkg::CMD_ALL, t[7:0], 32'h0, 3'd0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_cmds.size() < 60);
		quiet = 1'b1;
		wait (pending_cmds.size() == 0);
		@(posedge clk);
		while (cmd_ch.valid || expected_res.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
rtl/mlt_pkg.sv
rtl/mlt_if.sv
rtl/mlt_ctrl.sv
rtl/mlt_dp.sv
rtl/multimode_lock_table.sv
tb/multimode_lock_table_test.sv
